@@ rtl/core/kvp_pkg.sv @@
// types, codes and helpers shared by the key=value parser
package kvp_pkg;

  localparam int IndexWidth = 16;
  localparam int PosWidth   = 16;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChEquals    = 8'h3D;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;

  typedef logic [IndexWidth-1:0] idx_t;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_KEY    = 3'd1,
    PH_VSTART = 3'd2,
    PH_BARE   = 3'd3,
    PH_QUOTED = 3'd4,
    PH_ESCAPE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_VAL     = 2'd1,
    KIND_VEND    = 2'd2,
    KIND_ABANDON = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          byte_out;
    logic [PosWidth-1:0] position;
    logic                key_last;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
    phase_t  phase_nxt;
    idx_t    idx_nxt;
  } step_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr)) || (c == ChComma);
  endfunction

  function automatic logic [PosWidth-1:0] pos_sat(input idx_t idx);
    logic [IndexWidth+PosWidth-1:0] wide;
    logic [IndexWidth+PosWidth-1:0] lim;
    wide = {{PosWidth{1'b0}}, idx};
    lim  = (IndexWidth+PosWidth)'({PosWidth{1'b1}});
    if (wide > lim) begin
      return {PosWidth{1'b1}};
    end
    return wide[PosWidth-1:0];
  endfunction

  function automatic idx_t bump(input idx_t idx);
    if (idx != {IndexWidth{1'b1}}) begin
      return idx + IndexWidth'(1);
    end
    return idx;
  endfunction

endpackage

@@ rtl/core/kvp_decode.sv @@
// per-character decision: next phase, next index and the result to send
module kvp_decode
  import kvp_pkg::*;
(
  input  phase_t     phase,
  input  idx_t       idx,
  input  logic [7:0] ch,
  output step_t      step
);

  idx_t                bumped;
  logic [PosWidth-1:0] pos;
  logic                is_nul;
  logic                sep;

  assign bumped = bump(idx);
  assign pos    = pos_sat(idx);
  assign is_nul = (ch == ChNul);
  assign sep    = is_sep(ch);

  always_comb begin
    step.emit         = 1'b0;
    step.res.kind     = KIND_KEY;
    step.res.byte_out = ch;
    step.res.position = '0;
    step.res.key_last = 1'b0;
    step.phase_nxt    = phase;
    step.idx_nxt      = idx;
    unique case (phase)
      PH_KEY: begin
        step.emit = 1'b1;
        if (is_nul) begin
          step.phase_nxt    = PH_SKIP;
          step.idx_nxt      = '0;
          step.res.kind     = KIND_ABANDON;
          step.res.byte_out = '0;
        end else if (ch == ChEquals) begin
          step.phase_nxt    = PH_VSTART;
          step.idx_nxt      = '0;
          step.res.position = pos;
          step.res.key_last = 1'b1;
        end else begin
          step.idx_nxt      = bumped;
          step.res.position = pos;
        end
      end
      PH_VSTART: begin
        if (is_nul || sep) begin
          step.emit         = 1'b1;
          step.phase_nxt    = PH_SKIP;
          step.idx_nxt      = '0;
          step.res.kind     = KIND_VEND;
          step.res.byte_out = '0;
        end else if (ch == ChQuote) begin
          step.phase_nxt = PH_QUOTED;
          step.idx_nxt   = '0;
        end else begin
          step.emit      = 1'b1;
          step.phase_nxt = PH_BARE;
          step.idx_nxt   = IndexWidth'(1);
          step.res.kind  = KIND_VAL;
        end
      end
      PH_BARE: begin
        step.emit         = 1'b1;
        step.res.position = pos;
        if (is_nul || sep) begin
          step.phase_nxt    = PH_SKIP;
          step.idx_nxt      = '0;
          step.res.kind     = KIND_VEND;
          step.res.byte_out = '0;
        end else begin
          step.idx_nxt  = bumped;
          step.res.kind = KIND_VAL;
        end
      end
      PH_QUOTED: begin
        step.res.position = pos;
        if (is_nul || (ch == ChQuote)) begin
          step.emit         = 1'b1;
          step.phase_nxt    = PH_SKIP;
          step.idx_nxt      = '0;
          step.res.kind     = KIND_VEND;
          step.res.byte_out = '0;
        end else if (ch == ChBackslash) begin
          step.phase_nxt = PH_ESCAPE;
        end else begin
          step.emit     = 1'b1;
          step.idx_nxt  = bumped;
          step.res.kind = KIND_VAL;
        end
      end
      PH_ESCAPE: begin
        step.emit         = 1'b1;
        step.res.position = pos;
        if (is_nul) begin
          step.phase_nxt    = PH_SKIP;
          step.idx_nxt      = '0;
          step.res.kind     = KIND_VEND;
          step.res.byte_out = '0;
        end else begin
          step.phase_nxt = PH_QUOTED;
          step.idx_nxt   = bumped;
          step.res.kind  = KIND_VAL;
        end
      end
      default: begin
        if (is_nul || sep) begin
          step.phase_nxt = PH_SKIP;
          step.idx_nxt   = '0;
        end else if (ch == ChEquals) begin
          step.emit         = 1'b1;
          step.phase_nxt    = PH_VSTART;
          step.idx_nxt      = '0;
          step.res.key_last = 1'b1;
        end else begin
          step.emit      = 1'b1;
          step.phase_nxt = PH_KEY;
          step.idx_nxt   = IndexWidth'(1);
        end
      end
    endcase
  end

endmodule

@@ rtl/core/key_value_pair_parser.sv @@
// key=value pair parser: input register, per-character decode, result register
//
// in_valid/in_stall/in_ch carries one text character per request; a zero
// character ends the text and returns the parser to its reset state.
// out_valid/out_stall carries zero or one result per character: out_kind
// (key byte, value byte, value end, key abandoned), out_byte_out,
// out_position (index within key or value, or value length; saturating)
// and out_key_last on the closing '=' of a key.
// The opening quote mark, a backslash that escapes inside quotes and separators
// between pairs produce no result; the closing quote mark gives the value end.
// A result becomes valid in the result register once its character's decode moves on.
// Throughput: one character per cycle unless out_stall holds back a result,
// limited by the single decode stage between the input and result registers.
// Stall: while out_stall holds a waiting result, the next character may still
// be accepted into the input register; characters that produce no result keep
// moving. in_stall rises only when the input register holds a character whose
// result has no free slot.
// Reset (rst_n low, synchronous) empties both registers and sets the parser to
// skip separators with index zero.
module key_value_pair_parser
  import kvp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_ch,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_byte_out,
  output logic [PosWidth-1:0] out_position,
  output logic                out_key_last
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_ch_r;
  phase_t     phase_r;
  idx_t       idx_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  step_t      step;
  logic       out_free;
  logic       s1_go;
  logic       in_take;

  kvp_decode u_decode (
    .phase (phase_r),
    .idx   (idx_r),
    .ch    (s1_ch_r),
    .step  (step)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!step.emit || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && step.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SKIP;
      idx_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        phase_r <= step.phase_nxt;
        idx_r   <= step.idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r <= in_ch;
    end
    if (s1_go && step.emit) begin
      out_res_r <= step.res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_res_r.kind;
  assign out_byte_out = out_res_r.byte_out;
  assign out_position = out_res_r.position;
  assign out_key_last = out_res_r.key_last;

`ifndef NO_ASSERTIONS
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_ch_r == ChNul)) |=> (phase_r == PH_SKIP) && (idx_r == '0))
    else $error("end of text did not reset parser state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_res_r))
    else $error("waiting result lost or changed");

  a_last_is_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.key_last) |-> (out_res_r.kind == KIND_KEY))
    else $error("key_last on a non-key result");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_res_r.kind == KIND_VEND) || (out_res_r.kind == KIND_ABANDON)))
      |-> (out_res_r.byte_out == '0))
    else $error("marker carries a nonzero byte");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && step.emit && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule
